/* rtl/gml1_pkg.sv */
// ----------------------------------------------------------------------------
// gml1_pkg
// Shared constants, types and the gradient arithmetic of the L1 gradient
// magnitude block.
// ----------------------------------------------------------------------------
package gml1_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int MIN_DIM     = 2;
    localparam int RESET_WIDTH = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MAG_MAX     = 255;

    // result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int MAX_RESULTS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             end_of_frame;
    } t_result;

    // position flags carried with a pixel into the compute stage
    typedef struct packed {
        logic emit_a;    // column 0, row >= 2: right-border result of row r-2
        logic emit_b;    // column >= 1, row >= 1: result (r-1, c-1)
        logic last_row;
        logic last_col;
        logic row_is1;
        logic row_is2;
        logic col_is1;
    } t_s1_flags;

    function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        absd = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [PIX_W-1:0] grad_mag(
        input logic [PIX_W-1:0] top,
        input logic [PIX_W-1:0] ctr,
        input logic [PIX_W-1:0] bot,
        input logic [PIX_W-1:0] left,
        input logic [PIX_W-1:0] right,
        input logic             at_top,
        input logic             at_bot,
        input logic             at_left,
        input logic             at_right
    );
        logic [PIX_W:0]   gx;
        logic [PIX_W:0]   gy;
        logic [PIX_W+1:0] s;
        if (at_left) begin
            gx = {absd(right, ctr), 1'b0};
        end else if (at_right) begin
            gx = {absd(ctr, left), 1'b0};
        end else begin
            gx = {1'b0, absd(left, right)};
        end
        if (at_top) begin
            gy = {absd(bot, ctr), 1'b0};
        end else if (at_bot) begin
            gy = {absd(ctr, top), 1'b0};
        end else begin
            gy = {1'b0, absd(top, bot)};
        end
        s = {1'b0, gx} + {1'b0, gy};
        grad_mag = (s > (PIX_W+2)'(MAG_MAX)) ? PIX_W'(MAG_MAX) : s[PIX_W-1:0];
    endfunction

endpackage

/* rtl/gml1_pix_if.sv */
// ----------------------------------------------------------------------------
// gml1_pix_if
// Pixel stream channel: valid/ready handshake carrying one grey pixel a beat.
// ----------------------------------------------------------------------------
interface gml1_pix_if import gml1_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

/* rtl/gml1_mag_if.sv */
// ----------------------------------------------------------------------------
// gml1_mag_if
// Result channel: valid/ready handshake carrying one magnitude a beat.
// ----------------------------------------------------------------------------
interface gml1_mag_if import gml1_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] magnitude;
    logic             end_of_frame;

    modport source (output valid, output magnitude, output end_of_frame, input ready);
    modport sink   (input valid, input magnitude, input end_of_frame, output ready);

endinterface

/* rtl/gradient_magnitude_l1.sv */
// ----------------------------------------------------------------------------
// gradient_magnitude_l1
// Streaming L1 gradient magnitude of a grey frame. Two line stores in RAM
// feed a 3x2 pixel window; central differences inside, doubled one-sided
// differences on the borders, sum saturated at 255.
//
//   channel   dir  beat payload               handshake
//   i_pix     in   pixel[7:0]                 valid/ready
//   o_mag     out  magnitude[7:0], eof        valid/ready
//   i_cfg_*   in   index[0], data[11:0]       write enable, no wait
//
// One pixel a cycle while ready is high: line stores are read in the accept cycle
// and written back in the next, where the result is formed and queued. Output
// runs one row plus one pixel behind; last-row pixels past column 0 yield two
// results (the last pixel four), so input is held off there at the one-beat-a-cycle
// output rate. Reset (synchronous) restores 640x480 and restarts the frame; line
// stores are not cleared. Ready drops only when the 8-entry result queue is short
// of room for the next pixel's results.
// ----------------------------------------------------------------------------
module gradient_magnitude_l1 import gml1_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gml1_pix_if.sink             i_pix,
    gml1_mag_if.source           o_mag,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // frame geometry, stored as size minus one
    logic [COL_W-1:0] r_wm1;
    logic [ROW_W-1:0] r_hm1;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // compute stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    t_s1_flags        r_s1_flags;

    // window: index 0 = column c-1, index 1 = column c-2
    logic [PIX_W-1:0] r_top0, r_top1, r_mid0, r_mid1, r_bot0, r_bot1;

    // result queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   n_cnt;

    logic             accept;
    logic             pop;
    logic [2:0]       push_n;
    logic [PIX_W-1:0] rd_older, rd_prev;
    t_result          slot [MAX_RESULTS];
    t_result          res_a, res_b, res_c, res_d, res_e;
    logic [31:0]      cfg_v, cfg_w, cfg_h;
    logic             h_is2;

    assign accept = i_pix.valid && i_pix.ready;
    assign pop    = o_mag.valid && o_mag.ready;

    // ---------------- line stores ----------------
    gml1_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (rd_prev),
        .i_raddr (r_col),
        .o_rdata (rd_older)
    );

    gml1_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_raddr (r_col),
        .o_rdata (rd_prev)
    );

    // ---------------- configuration ----------------
    always_comb begin
        cfg_v = 32'(i_cfg_data);
        cfg_w = cfg_v;
        cfg_h = cfg_v;
        if (cfg_v < 32'(MIN_DIM)) begin
            cfg_w = 32'(MIN_DIM);
            cfg_h = 32'(MIN_DIM);
        end
        if (cfg_v > 32'(MAX_WIDTH)) begin
            cfg_w = 32'(MAX_WIDTH);
        end
        if (cfg_v > 32'(MAX_HEIGHT)) begin
            cfg_h = 32'(MAX_HEIGHT);
        end
    end

    // ---------------- position counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= COL_W'(RESET_WIDTH - 1);
            r_hm1 <= ROW_W'(RESET_HEIGHT - 1);
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH: begin
                        r_wm1 <= COL_W'(cfg_w - 32'd1);
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_hm1 <= ROW_W'(cfg_h - 32'd1);
                    end
                    default: begin
                    end
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (r_col == r_wm1) begin
                    r_col <= '0;
                    r_row <= (r_row == r_hm1) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // ---------------- compute stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix            <= i_pix.pixel;
            r_s1_col            <= r_col;
            r_s1_flags.emit_a   <= (r_col == '0) && (r_row >= ROW_W'(2));
            r_s1_flags.emit_b   <= (r_col != '0) && (r_row != '0);
            r_s1_flags.last_row <= (r_row == r_hm1);
            r_s1_flags.last_col <= (r_col == r_wm1);
            r_s1_flags.row_is1  <= (r_row == ROW_W'(1));
            r_s1_flags.row_is2  <= (r_row == ROW_W'(2));
            r_s1_flags.col_is1  <= (r_col == COL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top0 <= '0;
            r_top1 <= '0;
            r_mid0 <= '0;
            r_mid1 <= '0;
            r_bot0 <= '0;
            r_bot1 <= '0;
        end else if (r_s1_valid) begin
            r_top1 <= r_top0;
            r_top0 <= rd_older;
            r_mid1 <= r_mid0;
            r_mid0 <= rd_prev;
            r_bot1 <= r_bot0;
            r_bot0 <= r_s1_pix;
        end
    end

    // ---------------- results ----------------
    assign h_is2 = (r_hm1 == ROW_W'(1));

    always_comb begin
        // right border of row r-2
        res_a.magnitude    = grad_mag(r_top0, r_mid0, r_bot0, r_mid1, '0,
                                      r_s1_flags.row_is2, 1'b0, 1'b0, 1'b1);
        res_a.end_of_frame = 1'b0;
        // (r-1, c-1)
        res_b.magnitude    = grad_mag(r_top0, r_mid0, r_bot0, r_mid1, rd_prev,
                                      r_s1_flags.row_is1, 1'b0, r_s1_flags.col_is1, 1'b0);
        res_b.end_of_frame = 1'b0;
        // last pixel of row h-2
        res_c.magnitude    = grad_mag(rd_older, rd_prev, r_s1_pix, r_mid0, '0,
                                      h_is2, 1'b0, 1'b0, 1'b1);
        res_c.end_of_frame = 1'b0;
        // (h-1, c-1)
        res_d.magnitude    = grad_mag(r_mid0, r_bot0, '0, r_bot1, r_s1_pix,
                                      1'b0, 1'b1, r_s1_flags.col_is1, 1'b0);
        res_d.end_of_frame = 1'b0;
        // last pixel of the frame
        res_e.magnitude    = grad_mag(rd_prev, r_s1_pix, '0, r_bot0, '0,
                                      1'b0, 1'b1, 1'b0, 1'b1);
        res_e.end_of_frame = 1'b1;
    end

    always_comb begin
        slot[0] = r_s1_flags.emit_a ? res_a : res_b;
        slot[1] = r_s1_flags.last_col ? res_c : res_d;
        slot[2] = res_d;
        slot[3] = res_e;
        push_n  = 3'd0;
        if (r_s1_valid) begin
            if (r_s1_flags.emit_a) begin
                push_n = 3'd1;
            end else if (r_s1_flags.emit_b) begin
                if (!r_s1_flags.last_row) begin
                    push_n = 3'd1;
                end else if (r_s1_flags.last_col) begin
                    push_n = 3'd4;
                end else begin
                    push_n = 3'd2;
                end
            end
        end
    end

    // ---------------- result queue ----------------
    // room for this beat's results plus the next pixel's worst case
    assign i_pix.ready = ((r_cnt + (FIFO_AW+1)'(push_n))
                          <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RESULTS));

    assign n_cnt = r_cnt + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) < push_n) begin
                r_fifo[r_wptr + FIFO_AW'(i)] <= slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + FIFO_AW'(push_n);
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_mag.valid        = (r_cnt != '0);
    assign o_mag.magnitude    = r_fifo[r_rptr].magnitude;
    assign o_mag.end_of_frame = r_fifo[r_rptr].end_of_frame;

    // ---------------- assertions ----------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((r_cnt + (FIFO_AW+1)'(push_n)) <= (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("compute stage pushes without room");

    a_s1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel lost before compute stage");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0))
        else $error("configuration write did not restart frame");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_wm1) && (r_row <= r_hm1))
        else $error("position counter beyond frame");

endmodule

/* rtl/gml1_ram.sv */
// ----------------------------------------------------------------------------
// gml1_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gml1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sim/gradient_magnitude_l1_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_magnitude_l1_test
// Self-checking bench for the L1 gradient magnitude block. A queue-fed driver
// streams frames of grey pixels while the sink stalls in random bursts. A
// line-store model predicts every magnitude and end-of-frame flag in order,
// and the monitor compares each output beat against it. Frame geometry is
// rewritten between frames, including clamped and minimal sizes.
// ----------------------------------------------------------------------------
module gradient_magnitude_l1_test;
    import gml1_pkg::*;

    localparam int ITEM_TARGET   = 320;
    localparam int SETTLE_CYCLES = 8;
    localparam int CALM_TAIL     = 60;

    typedef enum int {
        TEX_NOISE,
        TEX_RAMP,
        TEX_EDGES
    } t_texture;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    gml1_pix_if pix_ch ();
    gml1_mag_if mag_ch ();

    gradient_magnitude_l1 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_mag       (mag_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [PIX_W-1:0] pixel_backlog [$];
    t_result          pending_mags [$];
    int               mismatch_count = 0;
    int               src_idle_pct   = 0;
    int               snk_idle_pct   = 0;
    int               src_gap        = 0;
    int               snk_gap        = 0;
    int               ramp_base      = 0;

    // model state: two line stores, 3x2 window, raster position, geometry
    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] prior_line [MAX_WIDTH];
    logic [PIX_W-1:0] win [6];
    int               col_at;
    int               row_at;
    int               frame_w;
    int               frame_h;

    always #2 i_clk = ~i_clk;

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        mag_ch.ready = 1'b0;
    end

    function automatic int pix_dist(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [PIX_W-1:0] l1_magnitude(
        input int top, input int ctr, input int bot, input int lft, input int rgt,
        input bit at_top, input bit at_bot, input bit at_lft, input bit at_rgt
    );
        int gx;
        int gy;
        if (at_lft) begin
            gx = 2 * pix_dist(rgt, ctr);
        end else if (at_rgt) begin
            gx = 2 * pix_dist(ctr, lft);
        end else begin
            gx = pix_dist(lft, rgt);
        end
        if (at_top) begin
            gy = 2 * pix_dist(bot, ctr);
        end else if (at_bot) begin
            gy = 2 * pix_dist(ctr, top);
        end else begin
            gy = pix_dist(top, bot);
        end
        return (gx + gy > MAG_MAX) ? PIX_W'(MAG_MAX) : PIX_W'(gx + gy);
    endfunction

    function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int top);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic void push_mag(input logic [PIX_W-1:0] mag, input logic eof);
        t_result r;
        r.magnitude    = mag;
        r.end_of_frame = eof;
        pending_mags = {pending_mags, r};
    endfunction

    // pixel at (r, c) releases (r-2, w-1) at column 0 and (r-1, c-1) otherwise;
    // the last row also releases its own column c-1, the last pixel four beats
    function automatic void advance_gradient(input logic [PIX_W-1:0] px);
        int c;
        int r;
        int t;
        int m;
        int b;
        c = col_at;
        r = row_at;
        if (c >= frame_w) c = 0;
        if (r >= frame_h) r = 0;
        t = upper_line[c];
        m = prior_line[c];
        b = px;
        if (c == 0 && r >= 2) begin
            push_mag(l1_magnitude(win[0], win[2], win[4], win[3], 0,
                                  r == 2, 1'b0, 1'b0, 1'b1), 1'b0);
        end
        if (c >= 1 && r >= 1) begin
            push_mag(l1_magnitude(win[0], win[2], win[4], win[3], m,
                                  r == 1, 1'b0, c == 1, 1'b0), 1'b0);
            if (r == frame_h - 1) begin
                if (c == frame_w - 1) begin
                    push_mag(l1_magnitude(t, m, b, win[2], 0,
                                          frame_h == 2, 1'b0, 1'b0, 1'b1), 1'b0);
                end
                push_mag(l1_magnitude(win[2], win[4], 0, win[5], b,
                                      1'b0, 1'b1, c == 1, 1'b0), 1'b0);
                if (c == frame_w - 1) begin
                    push_mag(l1_magnitude(m, b, 0, win[4], 0,
                                          1'b0, 1'b1, 1'b0, 1'b1), 1'b1);
                end
            end
        end
        win[1] = win[0];
        win[0] = t;
        win[3] = win[2];
        win[2] = m;
        win[5] = win[4];
        win[4] = b;
        upper_line[c] = m;
        prior_line[c] = b;
        c++;
        if (c >= frame_w) begin
            c = 0;
            r++;
            if (r >= frame_h) r = 0;
        end
        col_at = c;
        row_at = r;
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            pix_ch.pixel <= '0;
            src_gap      <= 0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (src_gap != 0) begin
                pix_ch.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end else if (pixel_backlog.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
                pix_ch.valid <= 1'b0;
                src_gap      <= $urandom_range(0, 16);
            end else if (pixel_backlog.size() != 0) begin
                pix_ch.valid <= 1'b1;
                pix_ch.pixel <= pixel_backlog.pop_front();
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mag_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end else if (snk_gap != 0) begin
            mag_ch.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end else if ($urandom_range(0, 99) < snk_idle_pct) begin
            mag_ch.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 16);
        end else begin
            mag_ch.ready <= 1'b1;
        end
    end

    // monitor: check output beats, then track register writes and input beats
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH; k++) begin
                upper_line[k] = '0;
                prior_line[k] = '0;
            end
            for (int k = 0; k < 6; k++) win[k] = '0;
            col_at  = 0;
            row_at  = 0;
            frame_w = RESET_WIDTH;
            frame_h = RESET_HEIGHT;
            pending_mags.delete();
        end else begin
            if (mag_ch.valid && mag_ch.ready) begin
                if (pending_mags.size() == 0) begin
                    $error("unexpected beat: magnitude %0d end_of_frame %0b",
                           mag_ch.magnitude, mag_ch.end_of_frame);
                    mismatch_count++;
                end else begin
                    want = pending_mags.pop_front();
                    if (mag_ch.magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, got %0d",
                               want.magnitude, mag_ch.magnitude);
                        mismatch_count++;
                    end
                    if (mag_ch.end_of_frame !== want.end_of_frame) begin
                        $error("end_of_frame: expected %0b, got %0b",
                               want.end_of_frame, mag_ch.end_of_frame);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    frame_w = clamp_dim(i_cfg_data, MAX_WIDTH);
                end else begin
                    frame_h = clamp_dim(i_cfg_data, MAX_HEIGHT);
                end
                col_at = 0;
                row_at = 0;
            end
            if (pix_ch.valid && pix_ch.ready) advance_gradient(pix_ch.pixel);
        end
    end

    task automatic wait_quiet(input int extra);
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || pix_ch.valid || pending_mags.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_pixels(input int w, input int k0, input int k1, input t_texture tex);
        @(negedge i_clk);
        for (int k = k0; k < k1; k++) begin
            case (tex)
                TEX_NOISE: begin
                    pixel_backlog = {pixel_backlog, PIX_W'($urandom_range(0, 255))};
                end
                TEX_RAMP: begin
                    pixel_backlog = {pixel_backlog,
                                     PIX_W'(ramp_base + 3 * (k % w) + 5 * (k / w)
                                            + $urandom_range(0, 3))};
                end
                default: begin
                    pixel_backlog = {pixel_backlog,
                                     ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int       w;
        int       h;
        int       n;
        int       frames;
        int       cut;
        int       f;
        bit       restart;
        bit       paused_once;
        t_texture tex;

        n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // row 0 under reset geometry, then abandoned by the register writes
        @(negedge i_clk);
        pixel_backlog = {8'hFF, 8'h00, 8'hAA};
        n += pixel_backlog.size();
        wait_quiet(SETTLE_CYCLES);
        // below-minimum values clamp to 2x2; all four beats leave on the last pixel
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        @(negedge i_clk);
        pixel_backlog = {8'h00, 8'hFF, 8'hFF, 8'h00};
        n += pixel_backlog.size();
        wait_quiet(SETTLE_CYCLES);
        write_reg(CFG_IMAGE_WIDTH, 12'd4);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        @(negedge i_clk);
        pixel_backlog = {8'd10, 8'd20, 8'd40, 8'd80,
                         8'd5, 8'd200, 8'd7, 8'd255,
                         8'd0, 8'd128, 8'd1, 8'd254};
        n += pixel_backlog.size();

        w           = 4;
        h           = 3;
        restart     = 1'b1;
        paused_once = 1'b0;
        while (n < ITEM_TARGET) begin
            @(negedge i_clk);
            if (n >= ITEM_TARGET - CALM_TAIL) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if ($urandom_range(0, 2) == 0) begin
                src_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(3, 40);
                snk_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(3, 40);
            end
            if (restart || $urandom_range(0, 2) != 0) begin
                wait_quiet(SETTLE_CYCLES);
                if (restart || $urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        w = MIN_DIM;
                        write_reg(CFG_IMAGE_WIDTH, CFG_W'($urandom_range(0, MIN_DIM - 1)));
                    end else begin
                        w = $urandom_range(2, 12);
                        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
                    end
                end
                if (restart || $urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        h = MIN_DIM;
                        write_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, MIN_DIM - 1)));
                    end else begin
                        h = $urandom_range(2, 6);
                        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
                    end
                end
                restart = 1'b0;
            end
            frames = $urandom_range(1, 2);
            for (f = 0; f < frames && !restart && n < ITEM_TARGET; f++) begin
                tex       = t_texture'($urandom_range(0, 2));
                ramp_base = $urandom_range(0, 255);
                cut       = w * h;
                // truncated frame, restarted by the next register write
                if ($urandom_range(0, 7) == 0) begin
                    cut     = $urandom_range(1, w * h - 1);
                    restart = 1'b1;
                end
                if (!paused_once || $urandom_range(0, 5) == 0) begin
                    queue_pixels(w, 0, cut / 2, tex);
                    wait_quiet(0);
                    paused_once = 1'b1;
                    queue_pixels(w, cut / 2, cut, tex);
                end else begin
                    queue_pixels(w, 0, cut, tex);
                end
                n += cut;
            end
        end

        wait_quiet(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("gradient_magnitude_l1_test: done, clean");
        end else begin
            $display("gradient_magnitude_l1_test: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("gradient_magnitude_l1_test: done, errors");
        $finish;
    end

endmodule
